>>> sv/esm_pkg.sv
`timescale 1ns / 1ps

package esm_pkg;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;
    localparam int VALUE_BITS = 32;

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PTR_W  = $clog2(LIST_DEPTH + 1);
    localparam int MEM_WORDS = NUM_LISTS * LIST_DEPTH;
    localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    // Port payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [LIST_W-1:0] t_list;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [MEM_AW-1:0] t_addr;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic  found;
        t_list idx;
    } t_sel;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] merged;
        logic [2:0]         src;
    } t_result;

    function automatic t_addr mem_addr(input t_list list, input t_ptr ptr);
        int unsigned a;
        a = int'(list) * LIST_DEPTH + int'(ptr);
        return MEM_AW'(a);
    endfunction

endpackage

>>> sv/esm_list_mem.sv
`timescale 1ns / 1ps

module esm_list_mem
    import esm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_we,
    input  t_addr  i_waddr,
    input  t_value i_wdata,
    input  logic   i_re,
    input  t_addr  i_raddr,
    output t_value o_rdata
);

    t_value r_mem [MEM_WORDS];
    t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/esm_head_select.sv
`timescale 1ns / 1ps

module esm_head_select
    import esm_pkg::*;
(
    input  t_value               i_heads [NUM_LISTS],
    input  logic [NUM_LISTS-1:0] i_nonempty,
    output t_sel                 o_sel
);

    localparam int NP = 2 ** LIST_W;

    // Heap-ordered comparison tree: node k has children 2k and 2k+1, leaves at NP+i.
    logic   node_vld [2*NP];
    t_value node_val [2*NP];
    t_list  node_idx [2*NP];

    always_comb begin
        logic take_right;
        for (int k = 0; k < 2*NP; k++) begin
            node_vld[k] = 1'b0;
            node_val[k] = '0;
            node_idx[k] = '0;
        end
        for (int i = 0; i < NP; i++) begin
            if (i < NUM_LISTS) begin
                node_vld[NP+i] = i_nonempty[i];
                node_val[NP+i] = i_heads[i];
            end
            node_idx[NP+i] = LIST_W'(i);
        end
        // Ties keep the left child, so the lower-numbered list wins.
        for (int k = NP - 1; k >= 1; k--) begin
            take_right = node_vld[2*k+1]
                         && (!node_vld[2*k] || (node_val[2*k+1] < node_val[2*k]));
            if (take_right) begin
                node_vld[k] = 1'b1;
                node_val[k] = node_val[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end else begin
                node_vld[k] = node_vld[2*k];
                node_val[k] = node_val[2*k];
                node_idx[k] = node_idx[2*k];
            end
        end
        o_sel.found = node_vld[1];
        o_sel.idx   = node_idx[1];
    end

endmodule

>>> sv/eight_way_sorted_merge_unit.sv
`timescale 1ns / 1ps
// Each result is registered, in the output register or in its skid entry.
// Load, clear and unused requests leave the input ready; a pop holds off the next request
// when the popped list still holds entries, because its head register is refilled from
// the list memory, whose read port is registered.
// Requests are also held off while both the output register and its skid entry are full.
// Reset (synchronous, active low) empties all lists and the output stage; no memory sweep.
module eight_way_sorted_merge_unit
    import esm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // list_index[2:0], value[34:3]
    input  logic [1:0]            i_s_axis_tuser,  // mode[1:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // merged_value[31:0], source_list[34:32]
    output logic [1:0]            o_m_axis_tuser   // status[1:0]
);

    t_value r_head_val [NUM_LISTS];
    t_ptr   r_head_ptr [NUM_LISTS];
    t_ptr   r_tail_cnt [NUM_LISTS];
    t_ptr   n_head_ptr [NUM_LISTS];
    t_ptr   n_tail_cnt [NUM_LISTS];

    logic    r_refill;
    t_list   r_refill_list;
    logic    r_out_vld, r_skd_vld;
    t_result r_out, r_skd;

    logic [NUM_LISTS-1:0] nonempty;
    t_sel   sel;
    t_value mem_rdata;

    logic       in_acc, out_acc;
    logic [1:0] in_mode;
    logic [2:0] in_idx;
    t_value     in_val;
    t_list      idx_l;
    logic       idx_ok;
    t_result    res;

    logic   mem_we, mem_re;
    t_addr  mem_waddr, mem_raddr;
    logic   load_head;
    logic   start_refill;
    t_ptr   next_ptr;

    assign in_mode = i_s_axis_tuser;
    assign in_idx  = i_s_axis_tdata[2:0];
    assign in_val  = VALUE_BITS'(signed'(i_s_axis_tdata[34:3]));
    assign idx_ok  = int'(in_idx) < NUM_LISTS;
    assign idx_l   = LIST_W'(in_idx);

    assign o_s_axis_tready = !r_refill && !r_skd_vld;
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = r_out_vld && i_m_axis_tready;

    always_comb begin
        for (int i = 0; i < NUM_LISTS; i++) begin
            nonempty[i] = r_head_ptr[i] < r_tail_cnt[i];
        end
    end

    esm_head_select u_select (
        .i_heads   (r_head_val),
        .i_nonempty(nonempty),
        .o_sel     (sel)
    );

    esm_list_mem u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(in_val),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        res          = '0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        load_head    = 1'b0;
        start_refill = 1'b0;
        mem_waddr    = mem_addr(idx_l, r_tail_cnt[idx_l]);
        next_ptr     = r_head_ptr[sel.idx] + PTR_W'(1);
        mem_raddr    = mem_addr(sel.idx, next_ptr);
        n_head_ptr   = r_head_ptr;
        n_tail_cnt   = r_tail_cnt;
        if (in_acc) begin
            unique case (in_mode)
                MODE_LOAD: begin
                    if (!idx_ok || r_tail_cnt[idx_l] >= PTR_W'(LIST_DEPTH)) begin
                        res.status = ST_FULL;
                    end else begin
                        mem_we = 1'b1;
                        // An empty list takes the new value straight into its head.
                        load_head = r_head_ptr[idx_l] == r_tail_cnt[idx_l];
                        n_tail_cnt[idx_l] = r_tail_cnt[idx_l] + PTR_W'(1);
                    end
                end
                MODE_POP: begin
                    if (!sel.found) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.merged = 32'(r_head_val[sel.idx]);
                        res.src    = 3'(sel.idx);
                        n_head_ptr[sel.idx] = next_ptr;
                        if (next_ptr < r_tail_cnt[sel.idx]) begin
                            mem_re       = 1'b1;
                            start_refill = 1'b1;
                        end
                    end
                end
                MODE_CLEAR: begin
                    for (int i = 0; i < NUM_LISTS; i++) begin
                        n_head_ptr[i] = '0;
                        n_tail_cnt[i] = '0;
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refill <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head_ptr[i] <= '0;
                r_tail_cnt[i] <= '0;
            end
        end else begin
            r_refill   <= start_refill;
            r_head_ptr <= n_head_ptr;
            r_tail_cnt <= n_tail_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_refill) begin
            r_refill_list <= sel.idx;
        end
        if (load_head) begin
            r_head_val[idx_l] <= in_val;
        end
        if (r_refill) begin
            r_head_val[r_refill_list] <= mem_rdata;
        end
    end

    // Two-entry output stage: a request can be taken while one result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            if (out_acc) begin
                if (r_skd_vld) begin
                    r_out_vld <= 1'b1;
                    r_skd_vld <= in_acc;
                end else begin
                    r_out_vld <= in_acc;
                end
            end else if (in_acc) begin
                if (r_out_vld) begin
                    r_skd_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            if (r_skd_vld) begin
                r_out <= r_skd;
                if (in_acc) begin
                    r_skd <= res;
                end
            end else if (in_acc) begin
                r_out <= res;
            end
        end else if (in_acc) begin
            if (r_out_vld) begin
                r_skd <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out.src, r_out.merged};
    assign o_m_axis_tuser  = r_out.status;

    logic ptr_order_ok;
    always_comb begin
        ptr_order_ok = 1'b1;
        for (int i = 0; i < NUM_LISTS; i++) begin
            if (r_head_ptr[i] > r_tail_cnt[i] || r_tail_cnt[i] > PTR_W'(LIST_DEPTH)) begin
                ptr_order_ok = 1'b0;
            end
        end
    end

    a_ptr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_order_ok)
        else $error("head pointer passed tail count or tail count passed depth");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid entry held while output register is empty");

    a_refill_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_refill |=> !r_refill)
        else $error("head refill lasted more than one cycle");

    a_refill_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_refill |-> !in_acc)
        else $error("request accepted during head refill");

endmodule
